### hw/rtl/biquad_cascade_lowpass_defines.svh
// assertion macros shared by the checker of this project
`ifndef BIQUAD_CASCADE_LOWPASS_DEFINES_SVH
`define BIQUAD_CASCADE_LOWPASS_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define BQC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define BQC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/bqc_pkg.sv
package bqc_pkg;

	localparam int MAX_SECTIONS_DEF   = 16;
	localparam int SAMPLE_WIDTH_DEF   = 24;
	localparam int COEF_FRAC_BITS_DEF = 22;

	localparam int COEF_W    = 25;
	localparam int DELAY_W   = 32;
	localparam int COUNT_W   = 5;
	localparam int SEC_IDX_W = 4;
	localparam int SEL_W     = 2;

	// fixed part of an input word beyond the sample
	localparam int IN_FIXED_W = SEC_IDX_W + SEL_W + COEF_W;

	localparam logic [COUNT_W-1:0] SECTIONS_RESET = 5'd16;

	// word kind on the input tuser
	localparam logic FUNC_FILTER = 1'b0;
	localparam logic FUNC_COEF   = 1'b1;

	// coefficient selects
	localparam logic [SEL_W-1:0] SEL_K  = 2'd0;
	localparam logic [SEL_W-1:0] SEL_A1 = 2'd1;
	localparam logic [SEL_W-1:0] SEL_A2 = 2'd2;

endpackage

### hw/rtl/biquad_cascade_lowpass.sv
// lowpass filter built from a cascade of second-order sections, direct form ii
// input stream: each word is either a sample to filter (tuser low) or a
// coefficient load (tuser high) of k, a1 or a2 for one section; a load also
// clears every section delay. only samples produce an output word.
// output stream: filtered sample with a clip flag on tuser.
// cfg_we/cfg_wdata set the number of active sections (reset 16) and clear
// the delays; write it only while no sample is in flight.
// one multiplier and one accumulator are shared by all sections; each active
// section steps through three coefficient reads from the single-port
// coefficient store, three multiplies, rounding and the output sum.
// the input stays ready while coefficient words are taken.
// tready on the input is low while a sample is processed.
// reset clears the coefficient and delay valid bits, so everything reads
// as zero, and sets the section count to 16.
// a stalled output word is held in its register; the next sample is still
// accepted and waits before the output until that word has gone.
module biquad_cascade_lowpass
	import bqc_pkg::*;
#(
	parameter int MAX_SECTIONS   = MAX_SECTIONS_DEF,
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
	localparam int IN_W  = ((SAMPLE_WIDTH + IN_FIXED_W + 7) / 8) * 8,
	localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// sample_in, section_index, coef_select, coef_value
	input  logic [IN_W-1:0]    s_axis_tdata,
	// func
	input  logic               s_axis_tuser,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// sample_out
	output logic [OUT_W-1:0]   m_axis_tdata,
	// clipped
	output logic               m_axis_tuser,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata
);

	localparam int SEC_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int NCNT_W = $clog2(MAX_SECTIONS + 1);
	localparam int COEF_N = 3 * MAX_SECTIONS;
	localparam int CA_W   = $clog2(COEF_N);
	localparam int PROD_W = COEF_W + DELAY_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int Y_W    = DELAY_W + 2;

	localparam logic signed [ACC_W-1:0] RND =
		ACC_W'({{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1));
	localparam logic signed [DELAY_W-1:0] DLY_MAX = {1'b0, {(DELAY_W-1){1'b1}}};
	localparam logic signed [DELAY_W-1:0] DLY_MIN = {1'b1, {(DELAY_W-1){1'b0}}};
	localparam logic [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_RD   = 9'b000000010,
		ST_KX   = 9'b000000100,
		ST_A1   = 9'b000001000,
		ST_A2   = 9'b000010000,
		ST_ACC  = 9'b000100000,
		ST_W    = 9'b001000000,
		ST_Y    = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	logic [COUNT_W-1:0] count_q;
	logic [NCNT_W-1:0]  n_eff;
	logic [NCNT_W-1:0]  sec_q;
	logic [SEC_W-1:0]   sec_idx;
	logic               sec_last;

	// input word fields
	logic signed [SAMPLE_WIDTH-1:0] in_sample;
	logic [SEC_IDX_W-1:0]           in_idx;
	logic [SEL_W-1:0]               in_sel;
	logic signed [COEF_W-1:0]       in_coef;
	logic                           in_acc;
	logic                           smp_acc;
	logic                           coef_wr;
	logic [CA_W-1:0]                coef_waddr;
	logic                           dly_clr;

	// coefficient store
	logic signed [COEF_W-1:0] coef_mem [COEF_N];
	logic [COEF_N-1:0]        coef_vld_q;
	logic signed [COEF_W-1:0] coef_rd_q;
	logic                     coef_rv_q;
	logic [CA_W-1:0]          coef_addr_q;
	logic                     coef_re;

	// delay store, one row per section: {w2, w1}
	logic [2*DELAY_W-1:0]     dly_mem [MAX_SECTIONS];
	logic [MAX_SECTIONS-1:0]  dly_vld_q;
	logic [2*DELAY_W-1:0]     dly_rd_q;
	logic                     dly_rv_q;

	// shared datapath
	logic signed [COEF_W-1:0]  coef_eff;
	logic signed [DELAY_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   acc_sh;
	logic                      w_ok;
	logic signed [DELAY_W-1:0] w_d;
	logic signed [Y_W-1:0]     y_sum;
	logic                      y_ok;
	logic signed [DELAY_W-1:0] y_d;
	logic signed [DELAY_W-1:0] x_q, w_q, w1_q, w2_q;
	logic                      clip_q;
	logic                      fin_ok;
	logic [SAMPLE_WIDTH-1:0]   fin_sample;

	// output register
	logic                    out_valid_q;
	logic [SAMPLE_WIDTH-1:0] out_sample_q;
	logic                    out_clip_q;
	logic                    out_load;

	assign in_sample = s_axis_tdata[SAMPLE_WIDTH-1:0];
	assign in_idx    = s_axis_tdata[SAMPLE_WIDTH+SEC_IDX_W-1:SAMPLE_WIDTH];
	assign in_sel    = s_axis_tdata[SAMPLE_WIDTH+SEC_IDX_W+SEL_W-1:SAMPLE_WIDTH+SEC_IDX_W];
	assign in_coef   = s_axis_tdata[SAMPLE_WIDTH+IN_FIXED_W-1:SAMPLE_WIDTH+SEC_IDX_W+SEL_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign smp_acc       = in_acc && (s_axis_tuser == FUNC_FILTER);
	// out-of-range section or select leaves everything untouched
	assign coef_wr       = in_acc && (s_axis_tuser == FUNC_COEF)
		&& (in_sel == SEL_K || in_sel == SEL_A1 || in_sel == SEL_A2)
		&& (int'(in_idx) < MAX_SECTIONS);
	assign coef_waddr    = CA_W'(({2'b00, in_idx} << 1) + {2'b00, in_idx}
		+ {{SEC_IDX_W{1'b0}}, in_sel});
	assign dly_clr       = cfg_we | coef_wr;

	assign n_eff    = (int'(count_q) > MAX_SECTIONS) ? NCNT_W'(MAX_SECTIONS)
		: NCNT_W'(count_q);
	assign sec_idx  = sec_q[SEC_W-1:0];
	assign sec_last = (int'(sec_q) + 1 == int'(n_eff));
	assign coef_re  = (state_q == ST_RD) || (state_q == ST_KX) || (state_q == ST_A1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (smp_acc)
					state_d = (n_eff == '0) ? ST_OUT : ST_RD;
			end
			ST_RD:  state_d = ST_KX;
			ST_KX:  state_d = ST_A1;
			ST_A1:  state_d = ST_A2;
			ST_A2:  state_d = ST_ACC;
			ST_ACC: state_d = ST_W;
			ST_W:   state_d = ST_Y;
			ST_Y:   state_d = sec_last ? ST_OUT : ST_RD;
			ST_OUT: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= SECTIONS_RESET;
			sec_q       <= '0;
			coef_addr_q <= '0;
			coef_vld_q  <= '0;
			coef_rv_q   <= 1'b0;
			dly_vld_q   <= '0;
			dly_rv_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				count_q <= cfg_wdata;
			if (smp_acc) begin
				sec_q       <= '0;
				coef_addr_q <= '0;
			end else begin
				if (state_q == ST_Y)
					sec_q <= sec_q + 1'b1;
				if (coef_re)
					coef_addr_q <= coef_addr_q + 1'b1;
			end
			if (coef_wr)
				coef_vld_q[coef_waddr] <= 1'b1;
			if (coef_re)
				coef_rv_q <= coef_vld_q[coef_addr_q];
			if (dly_clr)
				dly_vld_q <= '0;
			else if (state_q == ST_Y)
				dly_vld_q[sec_idx] <= 1'b1;
			if (state_q == ST_RD)
				dly_rv_q <= dly_vld_q[sec_idx];
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (coef_wr)
			coef_mem[coef_waddr] <= in_coef;
		if (coef_re)
			coef_rd_q <= coef_mem[coef_addr_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_Y)
			dly_mem[sec_idx] <= {w1_q, w_q};
		if (state_q == ST_RD)
			dly_rd_q <= dly_mem[sec_idx];
	end

	// coefficients never written since reset read as zero
	assign coef_eff = coef_rv_q ? coef_rd_q : '0;

	always_comb begin
		case (state_q)
			ST_KX:   mul_b = x_q;
			ST_A1:   mul_b = w1_q;
			default: mul_b = w2_q;
		endcase
	end

	// round half up, then saturate to the delay width
	assign acc_sh = acc_q >>> COEF_FRAC_BITS;
	assign w_ok   = (&acc_sh[ACC_W-1:DELAY_W-1]) | ~(|acc_sh[ACC_W-1:DELAY_W-1]);
	assign w_d    = w_ok ? acc_sh[DELAY_W-1:0] : (acc_sh[ACC_W-1] ? DLY_MIN : DLY_MAX);

	assign y_sum = Y_W'(w_q) + (Y_W'(w1_q) <<< 1) + Y_W'(w2_q);
	assign y_ok  = (&y_sum[Y_W-1:DELAY_W-1]) | ~(|y_sum[Y_W-1:DELAY_W-1]);
	assign y_d   = y_ok ? y_sum[DELAY_W-1:0] : (y_sum[Y_W-1] ? DLY_MIN : DLY_MAX);

	assign fin_ok     = (&x_q[DELAY_W-1:SAMPLE_WIDTH-1]) | ~(|x_q[DELAY_W-1:SAMPLE_WIDTH-1]);
	assign fin_sample = fin_ok ? x_q[SAMPLE_WIDTH-1:0]
		: (x_q[DELAY_W-1] ? SMP_MIN : SMP_MAX);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(coef_eff) * PROD_W'(mul_b);
		if (smp_acc) begin
			x_q    <= DELAY_W'(in_sample);
			clip_q <= 1'b0;
		end
		case (state_q)
			ST_KX: begin
				w1_q <= dly_rv_q ? dly_rd_q[DELAY_W-1:0] : '0;
				w2_q <= dly_rv_q ? dly_rd_q[2*DELAY_W-1:DELAY_W] : '0;
			end
			ST_A1:  acc_q <= ACC_W'(prod_q) + RND;
			ST_A2:  acc_q <= acc_q - ACC_W'(prod_q);
			ST_ACC: acc_q <= acc_q - ACC_W'(prod_q);
			ST_W: begin
				w_q    <= w_d;
				clip_q <= clip_q | ~w_ok;
			end
			ST_Y: begin
				x_q    <= y_d;
				clip_q <= clip_q | ~y_ok;
			end
			default: ;
		endcase
	end

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sample_q <= fin_sample;
			out_clip_q   <= clip_q | ~fin_ok;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_sample_q);
	assign m_axis_tuser  = out_clip_q;

endmodule

### hw/rtl/bqc_checker.sv
`include "biquad_cascade_lowpass_defines.svh"

module bqc_checker
	import bqc_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             s_axis_tuser,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata,
	input logic             m_axis_tuser
);

	// stalled output word is held
	`BQC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while stalled")

	// a sample keeps the input busy
	`BQC_ASSERT_NEXT(a_busy_after_sample, s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_FILTER), !s_axis_tready, "input ready right after a sample")

	// the input is ready again in the cycle after a coefficient load
	`BQC_ASSERT_NEXT(a_coef_one_cycle, s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_COEF), s_axis_tready, "input not ready after a coefficient load")

	// a new output word only comes out of a busy period
	`BQC_ASSERT_SAME(a_out_from_work, $rose(m_axis_tvalid), $past(!s_axis_tready), "output word without a sample in work")

endmodule

bind biquad_cascade_lowpass bqc_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_bqc_checker (.*);
